>>> rtl/bdc_pkg.sv
// Package with the shared types, constants and sizing function of the decimal converter.
`timescale 1ns / 1ps

package bdc_pkg;

   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int DIGIT_BITS = 4;
   localparam int CHAR_BITS = 6;

   // ASCII '-' and the upper bits shared by all codes of '0' to '9'.
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
   localparam logic [1:0] CHAR_DIGIT_HI = 2'b11;

   localparam logic [DIGIT_BITS-1:0] DIGIT_ADJUST_MIN = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DIGIT_ADJUST = 4'd3;
   localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = 4'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_EMIT
   } bdc_state_type;

   typedef struct packed {
      logic clear;
      logic convert;
      logic advance;
   } cell_ctrl_type;

   // Decimal digits needed for the largest magnitude, 2^(bits-1).
   function automatic int digit_count(input int bits);
      int count;
      count = ((bits - 1) * 30103) / 100000 + 1;
      return count;
   endfunction

endpackage

>>> rtl/binary_to_decimal_ascii.sv
// Top level of the signed binary to decimal ASCII converter.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_value
//   rsp      out        rsp_valid, rsp_stall, rsp_character, rsp_last
//
// One number is loaded, shifted bit by bit with adjust through the digit cell
// chain, followed by the sign when negative, and then drained from the chain
// one digit cell at a time.
// Leading zero cells are dropped while draining and give no transfer.
// Reset clears the controller and the output valid; the cells hold no reset.
// A stall on rsp holds the chain until the output register is free again.
`timescale 1ns / 1ps

module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = bdc_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [VALUE_BITS-1:0]    req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bdc_pkg::CHAR_BITS-1:0]   rsp_character,
   output logic                            rsp_last
);
   import bdc_pkg::*;

   localparam int NDIG = digit_count(VALUE_BITS);
   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam int REM_W = $clog2(NDIG + 1);

   bdc_state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic                  neg_ff, neg_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]  rsp_character_ff, rsp_character_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  load_out;
   logic [VALUE_BITS-1:0] raw;
   cell_ctrl_type         ctrl;
   logic [DIGIT_BITS-1:0] top_digit;

   logic                  carry_w [NDIG+1];
   logic [DIGIT_BITS-1:0] digit_w [NDIG];

   assign raw = req_value;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign top_digit = digit_w[NDIG-1];

   // Digit chain: the magnitude enters at cell 0 most significant bit first.
   assign carry_w[0] = mag_ff[VALUE_BITS-1];

   for (genvar i = 0; i < NDIG; i++) begin : g_cell
      logic [DIGIT_BITS-1:0] neighbor;
      if (i == 0) begin : g_first
         assign neighbor = '0;
      end else begin : g_rest
         assign neighbor = digit_w[i-1];
      end
      bdc_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .carry_in  (carry_w[i]),
         .digit_in  (neighbor),
         .carry_out (carry_w[i+1]),
         .digit_out (digit_w[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && rem_ff == REM_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      mag_in = mag_ff;
      bit_cnt_in = bit_cnt_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      started_in = started_ff;
      load_out = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.clear = 1'b1;
               neg_in = raw[VALUE_BITS-1];
               // The most negative value maps onto its unsigned magnitude.
               mag_in = raw[VALUE_BITS-1] ?
                        (~raw) + {{(VALUE_BITS-1){1'b0}}, 1'b1} : raw;
               bit_cnt_in = CNT_W'(VALUE_BITS - 1);
               rem_in = REM_W'(NDIG);
               started_in = 1'b0;
            end
         end
         ST_CONVERT: begin
            ctrl.convert = 1'b1;
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
         end
         ST_SIGN: begin
            if (out_free) begin
               load_out = 1'b1;
               rsp_character_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ctrl.advance = 1'b1;
               rem_in = rem_ff - 1'b1;
               // Leading zeros are dropped, but the units digit always goes out.
               if (started_ff || top_digit != '0 || rem_ff == REM_W'(1)) begin
                  load_out = 1'b1;
                  rsp_character_in = {CHAR_DIGIT_HI, top_digit};
                  rsp_last_in = (rem_ff == REM_W'(1));
                  started_in = 1'b1;
               end
            end
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         started_ff <= 1'b0;
         rem_ff <= '0;
         bit_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff <= started_in;
         rem_ff <= rem_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      if (load_out) begin
         rsp_character_ff <= rsp_character_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_chain_overflow: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONVERT |-> !carry_w[NDIG])
      else $error("digit chain overflowed out of the top cell");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> rem_ff != '0)
      else $error("emit state entered with no digits left");

   a_last_ends_number: assert property (@(posedge clock) disable iff (reset)
      load_out && rsp_last_in |=> state_ff == ST_IDLE)
      else $error("last character loaded but converter did not return to idle");

   a_top_digit_decimal: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> top_digit <= DIGIT_MAX)
      else $error("top cell holds a digit above nine");
`endif

endmodule

>>> rtl/bdc_cell.sv
// One BCD digit cell of the shift-and-adjust conversion chain.
`timescale 1ns / 1ps

module bdc_cell (
   input  logic                             clock,
   input  bdc_pkg::cell_ctrl_type           ctrl,
   input  logic                             carry_in,
   input  logic [bdc_pkg::DIGIT_BITS-1:0]   digit_in,
   output logic                             carry_out,
   output logic [bdc_pkg::DIGIT_BITS-1:0]   digit_out
);
   import bdc_pkg::*;

   logic [DIGIT_BITS-1:0] digit_ff;
   logic [DIGIT_BITS-1:0] digit_in_w;
   logic [DIGIT_BITS-1:0] adjusted;

   always_comb begin
      if (digit_ff >= DIGIT_ADJUST_MIN) begin
         adjusted = digit_ff + DIGIT_ADJUST;
      end else begin
         adjusted = digit_ff;
      end
   end

   assign carry_out = adjusted[DIGIT_BITS-1];

   // During conversion the cell shifts left through its neighbor; while
   // emitting, digits move one cell toward the top of the chain.
   always_comb begin
      if (ctrl.clear) begin
         digit_in_w = '0;
      end else if (ctrl.convert) begin
         digit_in_w = {adjusted[DIGIT_BITS-2:0], carry_in};
      end else if (ctrl.advance) begin
         digit_in_w = digit_in;
      end else begin
         digit_in_w = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_w;
   end

   assign digit_out = digit_ff;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps

module tb_top;
   import bdc_pkg::*;

   localparam int VB = 32;
   localparam int RAND_ITEMS = 470;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 64;
   localparam logic [CHAR_BITS-1:0] DIGIT_BASE = 6'd48;

   typedef struct {
      logic [CHAR_BITS-1:0] character;
      logic                 last;
   } text_char_type;

   class decimal_text_scoreboard;
      text_char_type pending_chars[$];
      int errors;
      int numbers_noted;
      int negatives_noted;
      int chars_checked;
      int longest_text;

      function new();
         errors = 0;
         numbers_noted = 0;
         negatives_noted = 0;
         chars_checked = 0;
         longest_text = 0;
      endfunction

      // Digits are collected least significant first, then queued in print order.
      function void note_value(input logic [VB-1:0] value);
         logic [VB-1:0] magnitude;
         logic [3:0]    digits[$];
         logic          negative;
         text_char_type tc;
         int            count;
         negative = value[VB-1];
         magnitude = negative ? (~value + 1'b1) : value;
         do begin
            digits.push_back(4'(magnitude % 10));
            magnitude = magnitude / 10;
         end while (magnitude != 0);
         count = digits.size();
         if (negative) begin
            tc.character = CHAR_MINUS;
            tc.last = 1'b0;
            pending_chars.push_back(tc);
            negatives_noted++;
            count++;
         end
         for (int i = digits.size() - 1; i >= 0; i--) begin
            tc.character = DIGIT_BASE + CHAR_BITS'(digits[i]);
            tc.last = (i == 0);
            pending_chars.push_back(tc);
         end
         if (count > longest_text)
            longest_text = count;
         numbers_noted++;
      endfunction

      task report_mismatch(input string msg);
         errors++;
         if (errors <= 40)
            $display("%0t mismatch: %s", $realtime, msg);
      endtask

      task check_char(input logic [CHAR_BITS-1:0] character, input logic last);
         text_char_type exp_char;
         chars_checked++;
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character %0d last %0b", character, last));
         end else begin
            exp_char = pending_chars.pop_front();
            if (character !== exp_char.character)
               report_mismatch($sformatf("character %0d, expected %0d",
                                         character, exp_char.character));
            if (last !== exp_char.last)
               report_mismatch($sformatf("last %0b, expected %0b on character %0d",
                                         last, exp_char.last, exp_char.character));
         end
      endtask

      function int pending_count();
         return pending_chars.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [VB-1:0]        req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CHAR_BITS-1:0] rsp_character;
   logic                 rsp_last;

   decimal_text_scoreboard sb = new();
   int cycle_count = 0;
   int stall_cycle = 0;
   int stall_mode = 0;
   int stall_hold = 0;
   int burst_left = 0;

   binary_to_decimal_ascii #(
      .VALUE_BITS(VB)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // The receiver switches between no stall, scattered stalls and long stall runs.
   always @(posedge clock) begin
      stall_cycle++;
      if (stall_cycle % 256 == 0)
         stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_hold > 0) begin
               stall_hold--;
               rsp_stall <= 1'b1;
            end else if ($urandom_range(0, 15) == 0) begin
               stall_hold = $urandom_range(1, 12);
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_value(req_value);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_char(rsp_character, rsp_last);
   end

   // Holds the value until a transfer happens; returns right after the accepting edge.
   task send_value(input logic [VB-1:0] value);
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         req_value <= $urandom;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Called after each transfer: bursts of random length separated by random gaps.
   task pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         idle_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10));
      end
   endtask

   // The first wait lets the monitor note a transfer taken at the edge just passed.
   task wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [VB-1:0] random_value();
      longint mag;
      int     width;
      logic [VB-1:0] v;
      case ($urandom_range(0, 5))
         0, 1: v = $urandom;
         2: begin
            width = $urandom_range(1, VB - 1);
            v = $urandom & ((32'h1 << width) - 1);
            if ($urandom_range(0, 1))
               v = -v;
         end
         3: v = VB'($signed($urandom_range(0, 40)) - 20);
         4: begin
            // Powers of ten and their neighbors exercise the digit count boundaries.
            mag = 1;
            repeat ($urandom_range(0, 9)) mag = mag * 10;
            mag = mag + $signed($urandom_range(0, 2)) - 1;
            v = VB'(mag);
            if ($urandom_range(0, 1))
               v = -v;
         end
         default: begin
            v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            v = v + VB'($signed($urandom_range(0, 6)) - 3);
         end
      endcase
      return v;
   endfunction

   initial begin
      logic [VB-1:0] directed[$];
      directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                   -32'sd100, 32'h7fffffff, 32'h80000000, 32'h80000001, 32'd1000000000,
                   32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd1234567890,
                   -32'sd1234567890, 32'h55555555, 32'haaaaaaaa, 32'h7ffffffe,
                   -32'sd9, 32'd4294967285};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_value(directed[i]);
         pace_sender();
      end
      // Let every character of the directed part come out before random traffic.
      wait_for_drain();

      for (int n = 0; n < RAND_ITEMS; n++) begin
         send_value(random_value());
         pace_sender();
         if (n == RAND_ITEMS / 2)
            wait_for_drain();
      end

      wait_for_drain();

      if (sb.pending_count() != 0)
         sb.report_mismatch($sformatf("%0d characters never arrived", sb.pending_count()));
      $display("converted %0d numbers (%0d negative), checked %0d characters",
               sb.numbers_noted, sb.negatives_noted, sb.chars_checked);
      $display("longest text %0d characters, %0d cycles, %0d mismatches",
               sb.longest_text, cycle_count, sb.errors);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/bdc_pkg.sv
rtl/bdc_cell.sv
rtl/binary_to_decimal_ascii.sv
test/tb_top.sv
